// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ttli_pkg.sv =====
// shared types and constants of the time table linear interpolator
// no dependencies; used by ttli_lerp and time_table_linear_interpolator
`default_nettype none

package ttli_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int TIME_BITS  = 32;
  localparam int DATA_BITS  = 32;
  localparam int IDX_BITS   = $clog2(MAX_POINTS);
  localparam int CNT_BITS   = IDX_BITS + 1;

  // configuration port
  localparam int CFG_ADDR_BITS = 1;
  localparam int CFG_DATA_BITS = CNT_BITS;
  localparam logic [CFG_ADDR_BITS-1:0] REG_POINTS_IN_USE = 1'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_TWO_CHANNEL   = 1'd1;

  // operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // divider of the interpolation lane: one quotient bit a cycle
  localparam int LERP_STEPS    = DATA_BITS;
  localparam int LERP_CNT_BITS = $clog2(LERP_STEPS);

  typedef struct packed {
    logic                        op;
    logic [IDX_BITS-1:0]         point_index;
    logic [TIME_BITS-1:0]        point_time;
    logic signed [DATA_BITS-1:0] point_value;
    logic signed [DATA_BITS-1:0] point_extra;
    logic [TIME_BITS-1:0]        query_time;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] main_result;
    logic signed [DATA_BITS-1:0] extra_result;
    logic                        in_range;
  } out_item_t;

  // one table point as held in the memory
  typedef struct packed {
    logic [TIME_BITS-1:0]        stamp;
    logic signed [DATA_BITS-1:0] main;
    logic signed [DATA_BITS-1:0] extra;
  } point_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CUR,
    ST_FWD,
    ST_BWD,
    ST_LO,
    ST_HI,
    ST_LERP,
    ST_DONE
  } ttli_state_t;

  typedef enum logic [2:0] {
    LP_IDLE,
    LP_DIFF,
    LP_ABS,
    LP_MUL,
    LP_DIV,
    LP_ADJ,
    LP_DONE
  } lerp_phase_t;

endpackage

`default_nettype wire

// ===== rtl/ttli_lerp.sv =====
// one interpolation lane: v1 + (v2 - v1) * dt / span, quotient toward zero
// depends on ttli_pkg; span must be nonzero and dt no larger than span
`default_nettype none

module ttli_lerp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [ttli_pkg::DATA_BITS-1:0] v1,
  input  logic signed [ttli_pkg::DATA_BITS-1:0] v2,
  input  logic [ttli_pkg::TIME_BITS-1:0]        dt,
  input  logic [ttli_pkg::TIME_BITS-1:0]        span,
  output logic                                 done,
  output logic signed [ttli_pkg::DATA_BITS-1:0] result
);
  import ttli_pkg::*;

  lerp_phase_t phase_r, phase_nxt;

  logic signed [DATA_BITS-1:0]   v1_r, v2_r;
  logic [TIME_BITS-1:0]          dt_r, span_r;
  logic [DATA_BITS:0]            dv_r;
  logic [DATA_BITS:0]            dv_neg;
  logic [DATA_BITS-1:0]          mag_r;
  logic                          neg_r;
  logic [DATA_BITS+TIME_BITS-1:0] prod_w;
  logic [TIME_BITS-1:0]          rem_r;
  logic [DATA_BITS-1:0]          low_r;
  logic [DATA_BITS-1:0]          quo_r;
  logic [LERP_CNT_BITS-1:0]      cnt_r;
  logic signed [DATA_BITS-1:0]   result_r;
  logic [TIME_BITS:0]            trial;
  logic [TIME_BITS:0]            trial_sub;
  logic                          fits;
  logic [DATA_BITS+1:0]          v1_ext, quo_ext, adj_w;

  assign dv_neg    = -dv_r;
  assign prod_w    = mag_r * dt_r;
  assign trial     = {rem_r, low_r[DATA_BITS-1]};
  assign fits      = trial >= {1'b0, span_r};
  assign trial_sub = trial - {1'b0, span_r};
  assign v1_ext    = {{2{v1_r[DATA_BITS-1]}}, v1_r};
  assign quo_ext   = {2'b00, quo_r};
  assign adj_w     = neg_r ? (v1_ext - quo_ext) : (v1_ext + quo_ext);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      LP_IDLE: if (start) phase_nxt = LP_DIFF;
      LP_DIFF: phase_nxt = LP_ABS;
      LP_ABS:  phase_nxt = LP_MUL;
      LP_MUL:  phase_nxt = LP_DIV;
      LP_DIV:  if (cnt_r == LERP_CNT_BITS'(LERP_STEPS - 1)) phase_nxt = LP_ADJ;
      LP_ADJ:  phase_nxt = LP_DONE;
      LP_DONE: phase_nxt = LP_IDLE;
      default: phase_nxt = LP_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done   = (phase_r == LP_DONE);
    result = result_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= LP_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (phase_r == LP_IDLE && start) begin
      v1_r   <= v1;
      v2_r   <= v2;
      dt_r   <= dt;
      span_r <= span;
    end
    unique case (phase_r)
      LP_DIFF: dv_r <= {v2_r[DATA_BITS-1], v2_r} - {v1_r[DATA_BITS-1], v1_r};
      LP_ABS: begin
        neg_r <= dv_r[DATA_BITS];
        mag_r <= dv_r[DATA_BITS] ? dv_neg[DATA_BITS-1:0] : dv_r[DATA_BITS-1:0];
      end
      // product < span * 2^DATA_BITS, so the upper half is already a remainder
      LP_MUL: begin
        rem_r <= prod_w[DATA_BITS+TIME_BITS-1:DATA_BITS];
        low_r <= prod_w[DATA_BITS-1:0];
        cnt_r <= '0;
      end
      LP_DIV: begin
        rem_r <= fits ? trial_sub[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
        low_r <= {low_r[DATA_BITS-2:0], 1'b0};
        quo_r <= {quo_r[DATA_BITS-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
      end
      LP_ADJ: result_r <= adj_w[DATA_BITS-1:0];
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/time_table_linear_interpolator.sv =====
// Piecewise linear interpolation over a loaded table of (time, value, extra) points.
// A load transaction (op 0) writes one point; it moves the interval cursor back to 0.
// A query transaction (op 1) walks the kept interval cursor forward or backward, one
// memory read per interval stepped, then interpolates both channels in two lanes that
// run side by side. The walk goes through the single read port of the point memory,
// the interpolation through the 32-step shift-subtract divider in each lane. One item
// is worked on at a time; the result sits in an output register, so the next
// transaction is taken while it waits.
// Times must not decrease across the points in use. The memory has no reset and no
// clearing pass: only loaded points may be covered by points_in_use.
// Depends on ttli_pkg, ttli_lerp and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module time_table_linear_interpolator (
  input  logic                                clk,
  input  logic                                rst_n,
  // input transactions
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ttli_pkg::in_item_t                  in_data,
  // result transactions
  output logic                                out_valid,
  input  logic                                out_stall,
  output ttli_pkg::out_item_t                 out_data,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [ttli_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [ttli_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import ttli_pkg::*;

  localparam logic [CNT_BITS-1:0] MAX_COUNT = CNT_BITS'(MAX_POINTS);

  // point memory, one read port with registered data
  point_t mem [MAX_POINTS];
  point_t rd_word_r;
  logic [IDX_BITS-1:0] rd_addr;

  // control state
  ttli_state_t          state_r, state_nxt;
  logic [IDX_BITS-1:0]  cursor_r, cursor_nxt;
  logic [CNT_BITS-1:0]  points_r;
  logic                 two_ch_r;
  logic                 out_valid_r, out_valid_nxt;

  // payload of the query in flight
  logic [IDX_BITS-1:0]  c_r, c_nxt;
  logic [TIME_BITS-1:0] q_r, q_nxt;
  point_t               lo_r, lo_nxt;
  out_item_t            res_r, res_nxt;
  out_item_t            out_data_r;

  // handshakes
  logic in_acc, load_acc, query_acc, out_load;

  // walk helpers
  logic [CNT_BITS-1:0]  size_w, size_m1, c_ext, c_p1, c_p2, cur_ext;
  logic [IDX_BITS-1:0]  last_idx, sat_idx, c_m1;
  logic                 q_gt, q_lt, q_eq;
  logic                 cur_last, fwd_more, bwd_more;

  // interpolation lanes
  logic [TIME_BITS-1:0]        dt_w, span_w;
  logic                        lerp_start;
  logic                        lerp_done, extra_done;
  logic signed [DATA_BITS-1:0] main_lerp, extra_lerp;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign load_acc  = in_acc && (in_data.op == OP_LOAD);
  assign query_acc = in_acc && (in_data.op == OP_QUERY);

  // output slot is free when empty or being drained this cycle
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // points in use, clamped to the table depth
  assign size_w   = (points_r > MAX_COUNT) ? MAX_COUNT : points_r;
  assign size_m1  = size_w - 1'b1;
  assign last_idx = size_m1[IDX_BITS-1:0];
  assign cur_ext  = {1'b0, cursor_r};
  // stale cursor saturates to the last point in use
  assign sat_idx  = (cur_ext >= size_w) ? last_idx : cursor_r;

  assign c_ext    = {1'b0, c_r};
  assign c_p1     = c_ext + 1'b1;
  assign c_p2     = c_ext + CNT_BITS'(2);
  assign c_m1     = c_r - 1'b1;

  // compare the query with the time just read
  assign q_gt     = q_r > rd_word_r.stamp;
  assign q_lt     = q_r < rd_word_r.stamp;
  assign q_eq     = q_r == rd_word_r.stamp;

  assign cur_last = (c_p1 >= size_w);
  assign fwd_more = q_gt && (c_p2 < size_w);
  assign bwd_more = q_lt && (c_r != '0);

  // interval operands: left point held in lo_r, right point on the read port
  assign dt_w   = q_r - lo_r.stamp;
  assign span_w = rd_word_r.stamp - lo_r.stamp;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (query_acc) begin
          state_nxt = (size_w == '0) ? ST_DONE : ST_CUR;
        end
      end
      // word at the cursor is on the read port
      ST_CUR: begin
        if (q_eq) begin
          state_nxt = ST_DONE;
        end else if (q_gt) begin
          state_nxt = cur_last ? ST_DONE : ST_FWD;
        end else begin
          state_nxt = (c_r == '0) ? ST_DONE : ST_BWD;
        end
      end
      // right end of interval c on the read port
      ST_FWD: begin
        if (!fwd_more) begin
          state_nxt = q_gt ? ST_DONE : ST_LO;
        end
      end
      // left end of interval c on the read port
      ST_BWD: begin
        if (!bwd_more) begin
          state_nxt = q_lt ? ST_DONE : ST_LO;
        end
      end
      ST_LO:   state_nxt = ST_HI;
      ST_HI:   state_nxt = (span_w == '0) ? ST_DONE : ST_LERP;
      ST_LERP: if (lerp_done) state_nxt = ST_DONE;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory addressing
  always_comb begin
    cursor_nxt    = cursor_r;
    c_nxt         = c_r;
    q_nxt         = q_r;
    lo_nxt        = lo_r;
    res_nxt       = res_r;
    rd_addr       = c_r;
    lerp_start    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (load_acc) begin
          cursor_nxt = '0;
        end else if (query_acc) begin
          q_nxt   = in_data.query_time;
          res_nxt = '0;
          if (size_w != '0) begin
            cursor_nxt = sat_idx;
            c_nxt      = sat_idx;
            rd_addr    = sat_idx;
          end
        end
      end
      ST_CUR: begin
        if (q_eq) begin
          // exact hit on the cursor point
          res_nxt.main_result  = rd_word_r.main;
          res_nxt.extra_result = two_ch_r ? rd_word_r.extra : '0;
          res_nxt.in_range     = 1'b1;
        end else if (q_gt) begin
          rd_addr = c_p1[IDX_BITS-1:0];
        end else if (c_r != '0) begin
          c_nxt   = c_m1;
          rd_addr = c_m1;
        end
      end
      ST_FWD: begin
        if (fwd_more) begin
          c_nxt   = c_p1[IDX_BITS-1:0];
          rd_addr = c_p2[IDX_BITS-1:0];
        end else begin
          cursor_nxt = c_r;
          rd_addr    = c_r;
        end
      end
      ST_BWD: begin
        if (bwd_more) begin
          c_nxt   = c_m1;
          rd_addr = c_m1;
        end else begin
          cursor_nxt = c_r;
          rd_addr    = c_r;
        end
      end
      ST_LO: begin
        lo_nxt  = rd_word_r;
        rd_addr = c_p1[IDX_BITS-1:0];
      end
      ST_HI: begin
        if (span_w == '0) begin
          // zero-width interval gives the left point
          res_nxt.main_result  = lo_r.main;
          res_nxt.extra_result = two_ch_r ? lo_r.extra : '0;
          res_nxt.in_range     = 1'b1;
        end else begin
          lerp_start = 1'b1;
        end
      end
      ST_LERP: begin
        if (lerp_done) begin
          res_nxt.main_result  = main_lerp;
          res_nxt.extra_result = two_ch_r ? extra_lerp : '0;
          res_nxt.in_range     = 1'b1;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cursor_r    <= '0;
      points_r    <= '0;
      two_ch_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_POINTS_IN_USE: points_r <= cfg_wdata;
          REG_TWO_CHANNEL:   two_ch_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    c_r   <= c_nxt;
    q_r   <= q_nxt;
    lo_r  <= lo_nxt;
    res_r <= res_nxt;
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  // point memory: write on load, read every cycle
  always_ff @(posedge clk) begin
    if (load_acc) begin
      mem[in_data.point_index] <= '{stamp: in_data.point_time,
                                    main:  in_data.point_value,
                                    extra: in_data.point_extra};
    end
    rd_word_r <= mem[rd_addr];
  end

  // main and extra lanes share dt and span and finish together
  ttli_lerp u_lerp_main (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (lerp_start),
    .v1     (lo_r.main),
    .v2     (rd_word_r.main),
    .dt     (dt_w),
    .span   (span_w),
    .done   (lerp_done),
    .result (main_lerp)
  );

  ttli_lerp u_lerp_extra (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (lerp_start),
    .v1     (lo_r.extra),
    .v2     (rd_word_r.extra),
    .dt     (dt_w),
    .span   (span_w),
    .done   (extra_done),
    .result (extra_lerp)
  );

  // a result only shows up from a finished query
  `ASSERT_NEXT(a_out_from_done, (state_r != ST_DONE) && !out_valid_r, !out_valid_r, "result without query")
  // lanes report only while the sequencer waits for them
  `ASSERT_IMPLY(a_lerp_in_wait, lerp_done, state_r == ST_LERP, "lane done outside wait")
  // both lanes run in lockstep
  `ASSERT_IMPLY(a_lanes_in_step, lerp_done, extra_done, "lanes out of step")
  // a load rewinds the cursor
  `ASSERT_NEXT(a_load_rewinds, load_acc, cursor_r == '0, "cursor not rewound by load")
  // out of range results carry zero values
  `ASSERT_IMPLY(a_oor_zero, out_valid_r && !out_data_r.in_range, (out_data_r.main_result == '0) && (out_data_r.extra_result == '0), "nonzero out of range result")

endmodule

`default_nettype wire
